FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// needs nothing but a clock and an active-low reset in the using scope

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the usual clk_i and rst_ni of the using scope
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/issp_pkg.sv
// types and constants of the image SSD population statistics block
// no dependencies
`timescale 1ns / 1ps

package issp_pkg;

  localparam int unsigned MAX_PIXELS     = 65536;
  localparam int unsigned MAX_POPULATION = 64;
  localparam int unsigned CHANNELS       = 3;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SCORE_W = 34;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned POP_W   = 7;
  // sum of three squared 8-bit differences
  localparam int unsigned PSUM_W  = 18;

  localparam logic [POP_W-1:0] POP_RESET = POP_W'(30);
  localparam logic [POP_W-1:0] POP_MAX   = POP_W'(MAX_POPULATION);

  // saturation point of the frame accumulator
  localparam logic [63:0] CAP_FULL  = 64'(MAX_PIXELS) * 64'(CHANNELS) * 64'd65025;
  localparam logic [63:0] SCORE_M64 = (64'd1 << SCORE_W) - 64'd1;
  localparam logic [SCORE_W-1:0] SCORE_CAP =
    (CAP_FULL > SCORE_M64) ? SCORE_M64[SCORE_W-1:0] : CAP_FULL[SCORE_W-1:0];

  // one quotient bit per divider step
  localparam int unsigned DIV_STEPS = SUM_W;

  typedef struct packed {
    logic [CHAN_W-1:0] rendered_red;
    logic [CHAN_W-1:0] rendered_green;
    logic [CHAN_W-1:0] rendered_blue;
    logic [CHAN_W-1:0] target_red;
    logic [CHAN_W-1:0] target_green;
    logic [CHAN_W-1:0] target_blue;
    logic              last_pixel;
  } issp_pix_t;

  typedef struct packed {
    logic [SCORE_W-1:0] frame_score;
    logic [IDX_W-1:0]   frame_index;
    logic               generation_done;
    logic [SCORE_W-1:0] min_score;
    logic [SCORE_W-1:0] max_score;
    logic [SCORE_W-1:0] mean_score;
    logic [IDX_W-1:0]   best_index;
  } issp_res_t;

  // controller to datapath
  typedef struct packed {
    logic latch_pixel;
    logic update_stats;
    logic start_div;
    logic load_result;
    logic advance_frame;
  } issp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic gen_end;
    logic div_done;
    logic out_free;
  } issp_sts_t;

  // squared difference of two channel values
  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

endpackage

FILE: rtl/issp_if.sv
// channel interfaces: pixel pairs in, frame results out, size register writes
// depends on issp_pkg
`timescale 1ns / 1ps

interface issp_pix_if import issp_pkg::*; ();
  logic      valid;
  logic      ready;
  issp_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface issp_res_if import issp_pkg::*; ();
  logic      valid;
  logic      ready;
  issp_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface issp_cfg_if import issp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/issp_div.sv
// restoring divider for the generation mean, one quotient bit per cycle
// depends on issp_pkg
`timescale 1ns / 1ps

module issp_div import issp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [POP_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  // divisor never exceeds 2**(POP_W-1), so the remainder fits one bit less
  localparam int unsigned REM_W = POP_W - 1;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] quot_q;
  logic [REM_W-1:0] rem_q;
  logic [POP_W-1:0] divisor_q;

  logic [POP_W-1:0] shifted;
  logic             ge;
  logic [POP_W-1:0] diff;

  // one trial subtraction
  assign shifted = {rem_q, quot_q[SUM_W-1]};
  assign ge      = (shifted >= divisor_q);
  assign diff    = shifted - divisor_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], ge};
      rem_q  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/issp_datapath.sv
// datapath: squared differences, frame accumulator, running statistics,
// size register and result register; depends on issp_pkg and issp_div
`timescale 1ns / 1ps

module issp_datapath import issp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  issp_cmd_t        cmd_i,
  output issp_sts_t        sts_o,
  input  issp_pix_t        pix_i,
  input  logic             cfg_valid_i,
  input  logic [POP_W-1:0] cfg_data_i,
  output logic             res_valid_o,
  output issp_res_t        res_data_o,
  input  logic             res_ready_i
);

  logic [POP_W-1:0]   pop_q;
  logic [POP_W-1:0]   pop_eff;

  logic [PSUM_W-1:0]  psum_d, psum_q;
  logic               s1_valid_q, s1_last_q;

  logic [SCORE_W:0]   acc_sum;
  logic [SCORE_W-1:0] acc_sat;
  logic [SCORE_W-1:0] acc_q, score_q;

  logic [IDX_W-1:0]   cnt_q;
  logic [SCORE_W-1:0] min_q, max_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W:0]     sum_add;
  logic [IDX_W-1:0]   minpos_q;
  logic               gen_end;

  logic               div_done;
  logic [SUM_W-1:0]   quot;

  logic               res_valid_q;
  issp_res_t          res_data_q;
  logic               out_free;

  // population size register and its clamped value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= POP_RESET;
    end else if (cfg_valid_i) begin
      pop_q <= cfg_data_i;
    end
  end

  assign pop_eff = (pop_q == '0) ? POP_W'(1) : ((pop_q > POP_MAX) ? POP_MAX : pop_q);

  // pixel stage: three squares summed
  assign psum_d = PSUM_W'(sq_diff(pix_i.rendered_red,   pix_i.target_red))
                + PSUM_W'(sq_diff(pix_i.rendered_green, pix_i.target_green))
                + PSUM_W'(sq_diff(pix_i.rendered_blue,  pix_i.target_blue));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.latch_pixel;
      if (cmd_i.latch_pixel) begin
        s1_last_q <= pix_i.last_pixel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_pixel) begin
      psum_q <= psum_d;
    end
  end

  // saturating frame accumulator
  assign acc_sum = {1'b0, acc_q} + (SCORE_W+1)'(psum_q);
  assign acc_sat = (acc_sum > (SCORE_W+1)'(SCORE_CAP)) ? SCORE_CAP : acc_sum[SCORE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      score_q <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        score_q <= acc_sat;
        acc_q   <= '0;
      end else begin
        acc_q <= acc_sat;
      end
    end
  end

  // running statistics over the generation
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(score_q);
  assign gen_end = (({1'b0, cnt_q}) + POP_W'(1)) >= pop_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= '0;
      sum_q    <= '0;
      minpos_q <= '0;
    end else if (cmd_i.update_stats) begin
      if (cnt_q == '0) begin
        min_q    <= score_q;
        max_q    <= score_q;
        sum_q    <= SUM_W'(score_q);
        minpos_q <= '0;
      end else begin
        if (score_q > max_q) begin
          max_q <= score_q;
        end
        if (score_q < min_q) begin
          min_q    <= score_q;
          minpos_q <= cnt_q;
        end
        sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
    end
  end

  // frame counter within the generation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.advance_frame) begin
      cnt_q <= gen_end ? '0 : (cnt_q + IDX_W'(1));
    end
  end

  // mean divider
  issp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (sum_q),
    .divisor_i  (pop_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // result register
  assign out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_data_q.frame_score     <= score_q;
      res_data_q.frame_index     <= cnt_q;
      res_data_q.generation_done <= gen_end;
      res_data_q.min_score       <= gen_end ? min_q : '0;
      res_data_q.max_score       <= gen_end ? max_q : '0;
      res_data_q.mean_score      <= gen_end ? quot[SCORE_W-1:0] : '0;
      res_data_q.best_index      <= gen_end ? minpos_q : '0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

  assign sts_o.gen_end  = gen_end;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = out_free;

endmodule

FILE: rtl/issp_ctrl.sv
// controller: sequences pixel intake, frame close, statistics, mean and result
// depends on issp_pkg
`timescale 1ns / 1ps

module issp_ctrl import issp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pix_valid_i,
  input  logic      pix_last_i,
  output logic      pix_ready_o,
  output issp_cmd_t cmd_o,
  input  issp_sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_ACCEPT    = 6'b000001,
    ST_FINISH    = 6'b000010,
    ST_STATS     = 6'b000100,
    ST_DIV_START = 6'b001000,
    ST_DIV_WAIT  = 6'b010000,
    ST_EMIT      = 6'b100000
  } issp_state_e;

  issp_state_e state_q, state_d;
  logic        pix_xfer;

  assign pix_ready_o = (state_q == ST_ACCEPT);
  assign pix_xfer    = pix_valid_i && pix_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.latch_pixel = pix_xfer;
    case (state_q)
      ST_ACCEPT: begin
        if (pix_xfer && pix_last_i) begin
          state_d = ST_FINISH;
        end
      end
      // last pixel passes through the accumulator
      ST_FINISH: begin
        state_d = ST_STATS;
      end
      ST_STATS: begin
        cmd_o.update_stats = 1'b1;
        state_d = sts_i.gen_end ? ST_DIV_START : ST_EMIT;
      end
      ST_DIV_START: begin
        cmd_o.start_div = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_result   = 1'b1;
          cmd_o.advance_frame = 1'b1;
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/image_ssd_population_stats.sv
// Pixel pairs are taken one per cycle within a frame. After the last pixel of a
// frame, intake pauses while the score closes and the statistics update; a
// generation-ending frame also waits for the bit-serial mean divider. Result
// appears in the output register after the statistics update (after the mean at
// generation end), later if the output is stalled. Asynchronous active-low reset
// clears all counters and statistics and sets the population size to 30.
`timescale 1ns / 1ps

module image_ssd_population_stats import issp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  issp_cfg_if.sink   cfg_i,
  issp_pix_if.sink   pix_i,
  issp_res_if.source res_o
);

  issp_cmd_t cmd;
  issp_sts_t sts;
  logic      pix_ready;

  // size register writes are always taken
  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = pix_ready;

  issp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_last_i  (pix_i.data.last_pixel),
    .pix_ready_o (pix_ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  issp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pix_i       (pix_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .res_valid_o (res_o.valid),
    .res_data_o  (res_o.data),
    .res_ready_i (res_o.ready)
  );

endmodule

FILE: rtl/issp_checker.sv
// port-level checks on the result channel of the top level, bound below
// depends on issp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module issp_checker import issp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      res_valid_i,
  input logic      res_ready_i,
  input issp_res_t res_data_i
);

  // a pending result is not withdrawn
  `ASSERT_DEF(a_res_hold, (res_valid_i && !res_ready_i) |=> res_valid_i, "result dropped before transfer")

  // summary range is ordered
  `ASSERT_DEF(a_min_le_max, (res_valid_i && res_data_i.generation_done) |-> (res_data_i.min_score <= res_data_i.max_score), "min score above max score")

  // fittest frame lies within the generation so far
  `ASSERT_DEF(a_best_idx, (res_valid_i && res_data_i.generation_done) |-> (res_data_i.best_index <= res_data_i.frame_index), "best index beyond frame index")

  // summary fields are zero mid-generation
  `ASSERT_DEF(a_summary_zero, (res_valid_i && !res_data_i.generation_done) |-> ((res_data_i.min_score == '0) && (res_data_i.max_score == '0) && (res_data_i.mean_score == '0) && (res_data_i.best_index == '0)), "summary fields set mid-generation")

  // frame score respects saturation
  `ASSERT_DEF(a_score_cap, res_valid_i |-> (res_data_i.frame_score <= SCORE_CAP), "frame score above cap")

endmodule

bind image_ssd_population_stats issp_checker u_issp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
